// ===== rtl/lrs_pkg.sv =====
package lrs_pkg;

  // Tree size and field widths
  localparam int unsigned CELLS  = 1024;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned IDX_W  = ADDR_W + 1;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned WORD_W = 2 * SUM_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(CELLS);

  // Request command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic pass_init;
    logic pass_sel;
    logic upd_wr;
    logic pre_acc;
    logic mul;
    logic fin;
    logic out_load;
  } lrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic empty;
    logic skip_second;
    logic clr_last;
    logic upd_last;
    logic pre_last;
    logic out_free;
  } lrs_stat_t;

endpackage

// ===== rtl/lazy_range_add_sum_tree.sv =====
// Range add / range sum over up to 1024 signed 64-bit cells.
// Input channel (in_valid_i / in_stall_o): command_i 0 adds add_value_i to
// cells range_low_i..range_high_i, command_i 1 asks for their sum. A request
// is taken when valid is high and stall is low; one request is worked on at
// a time. Output channel (out_valid_o / out_stall_i): one range_sum_o per sum
// request, held in an output register until taken. Add requests give none.
// Sums wrap modulo 2^64. The interval is clipped to active_length.
// Each request runs up to two passes over a 1024-entry single-port RAM
// holding two prefix trees (an empty interval runs none); a pass visits up
// to 11 indices, each with a RAM read and then a write or an accumulate,
// all through that one RAM port.
// A new request may be taken while a result still waits in the output
// register; a sum request that finds the register full waits for it.
// Reset, and every write of active_length (cfg_we_i), starts a clearing
// pass over all 1024 RAM words, one RAM word a cycle, during which in_stall_o is
// high; afterwards every cell reads zero.
module lazy_range_add_sum_tree (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lrs_pkg::LEN_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [lrs_pkg::POS_W-1:0]        range_low_i,
  input  logic [lrs_pkg::POS_W-1:0]        range_high_i,
  input  logic signed [lrs_pkg::VAL_W-1:0] add_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [lrs_pkg::SUM_W-1:0] range_sum_o
);

  import lrs_pkg::*;

  lrs_cmd_t  cmd;
  lrs_stat_t stat;

  lrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .command_i   (command_i),
    .range_low_i (range_low_i),
    .range_high_i(range_high_i),
    .add_value_i (add_value_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .range_sum_o (range_sum_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== rtl/lrs_ram.sv =====
module lrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/lrs_ctrl.sv =====
module lrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lrs_pkg::lrs_stat_t stat_i,
  output lrs_pkg::lrs_cmd_t  cmd_o
);

  import lrs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_URD   = 4'd3;
  localparam logic [3:0] S_UWR   = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_PACC  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;
  logic [3:0] done_state;

  assign in_stall_o = (state_q != S_IDLE);
  assign done_state = stat_i.is_query ? S_OUT : S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass_sel = pass_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pass_d     = 1'b0;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (stat_i.empty || (pass_q && stat_i.skip_second)) begin
          state_d = done_state;
        end else begin
          cmd_o.pass_init = 1'b1;
          state_d = stat_i.is_query ? S_PRD : S_URD;
        end
      end
      S_URD: state_d = S_UWR;
      S_UWR: begin
        cmd_o.upd_wr = 1'b1;
        state_d = stat_i.upd_last ? S_NEXT : S_URD;
      end
      S_PRD: state_d = S_PACC;
      S_PACC: begin
        cmd_o.pre_acc = 1'b1;
        state_d = stat_i.pre_last ? S_MUL : S_PRD;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = S_START;
        end else begin
          state_d = done_state;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // A length write rebuilds the tree
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

// ===== rtl/lrs_dp.sv =====
module lrs_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lrs_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic                        command_i,
  input  logic [lrs_pkg::POS_W-1:0]   range_low_i,
  input  logic [lrs_pkg::POS_W-1:0]   range_high_i,
  input  logic signed [lrs_pkg::VAL_W-1:0] add_value_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [lrs_pkg::SUM_W-1:0] range_sum_o,
  input  lrs_pkg::lrs_cmd_t           cmd_i,
  output lrs_pkg::lrs_stat_t          stat_o
);

  import lrs_pkg::*;

  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] clr_q;
  logic              query_q, empty_q;
  logic [IDX_W-1:0]  l_q, r_q, idx_q, pidx_q;
  logic signed [VAL_W-1:0] v_q;
  logic [SUM_W-1:0]  d1_q, d2_q, s1_q, s2_q, prod_q, res_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  out_q;

  logic [LEN_W-1:0]  len_eff, b_clip;
  logic              empty_in;
  logic [IDX_W-1:0]  lowbit, mul_idx;
  logic [IDX_W:0]    idx_up;
  logic [IDX_W-1:0]  idx_dn;
  logic signed [VAL_W+IDX_W:0] vmul;
  logic [SUM_W-1:0]  vmul_ext, v_ext, term;
  logic [SUM_W+IDX_W-1:0] pmul;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Interval clipping against the active length
  always_comb begin
    len_eff = len_q;
    if (len_q == '0) len_eff = LEN_W'(1);
    else if (len_q > LEN_W'(CELLS)) len_eff = LEN_W'(CELLS);
    b_clip = LEN_W'(range_high_i);
    if (b_clip > len_eff - LEN_W'(1)) b_clip = len_eff - LEN_W'(1);
    empty_in = (LEN_W'(range_low_i) >= len_eff) || (LEN_W'(range_low_i) > b_clip);
  end

  // Binary indexed tree stepping
  assign lowbit = idx_q & (~idx_q + IDX_W'(1));
  assign idx_up = {1'b0, idx_q} + {1'b0, lowbit};
  assign idx_dn = idx_q - lowbit;

  // Deltas for an update pass, and the product terms for a query
  assign mul_idx  = cmd_i.pass_sel ? r_q : (l_q - IDX_W'(1));
  assign vmul     = v_q * $signed({1'b0, mul_idx});
  assign vmul_ext = SUM_W'(vmul);
  assign v_ext    = SUM_W'(v_q);
  assign pmul     = s1_q * pidx_q;
  assign term     = prod_q - s2_q;

  assign stat_o.is_query    = query_q;
  assign stat_o.empty       = empty_q;
  assign stat_o.skip_second = query_q ? (l_q == IDX_W'(1)) : (r_q == IDX_W'(CELLS));
  assign stat_o.clr_last    = (clr_q == ADDR_W'(CELLS - 1));
  assign stat_o.upd_last    = (idx_up > (IDX_W + 1)'(CELLS));
  assign stat_o.pre_last    = (idx_dn == '0);
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  // Memory port: {pending-weighted, per-cell} word per index
  assign ram_we    = cmd_i.clr_step | cmd_i.upd_wr;
  assign ram_addr  = cmd_i.clr_step ? clr_q : ADDR_W'(idx_q - IDX_W'(1));
  assign ram_wdata = cmd_i.clr_step ? '0 :
                     {ram_rdata[WORD_W-1:SUM_W] + d2_q, ram_rdata[SUM_W-1:0] + d1_q};

  lrs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      query_q <= (command_i == CMD_SUM);
      empty_q <= empty_in;
      l_q     <= IDX_W'(range_low_i) + IDX_W'(1);
      r_q     <= IDX_W'(b_clip) + IDX_W'(1);
      v_q     <= add_value_i;
      res_q   <= '0;
    end
    if (cmd_i.pass_init) begin
      if (query_q) begin
        idx_q  <= cmd_i.pass_sel ? (l_q - IDX_W'(1)) : r_q;
        pidx_q <= cmd_i.pass_sel ? (l_q - IDX_W'(1)) : r_q;
        s1_q   <= '0;
        s2_q   <= '0;
      end else begin
        idx_q <= cmd_i.pass_sel ? (r_q + IDX_W'(1)) : l_q;
        d1_q  <= cmd_i.pass_sel ? (SUM_W'(0) - v_ext) : v_ext;
        d2_q  <= cmd_i.pass_sel ? (SUM_W'(0) - vmul_ext) : vmul_ext;
      end
    end
    if (cmd_i.upd_wr) idx_q <= IDX_W'(idx_up);
    if (cmd_i.pre_acc) begin
      s1_q  <= s1_q + ram_rdata[SUM_W-1:0];
      s2_q  <= s2_q + ram_rdata[WORD_W-1:SUM_W];
      idx_q <= idx_dn;
    end
    if (cmd_i.mul) prod_q <= pmul[SUM_W-1:0];
    if (cmd_i.fin) res_q <= cmd_i.pass_sel ? (res_q - term) : (res_q + term);
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = $signed(out_q);

endmodule

// ===== rtl/lrs_checker.sv =====
module lrs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // One request at a time: busy right after taking one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // A length write starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("not clearing after length write");

  // Clearing follows reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o)
    else $error("not clearing after reset");

endmodule

bind lazy_range_add_sum_tree lrs_checker u_lrs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_we_i   (cfg_we_i),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);
